// ===== rtl/core/isort_pkg.sv =====
`timescale 1ns / 1ps
// isort_pkg: shared constants and types for the insertion sorter
// no dependencies; used by isort_cell, insertion_sorter and the test bench
package isort_pkg;

  localparam int CAPACITY = 16;
  localparam int DATA_W   = 32;

  // one request: value to insert, last closes the set
  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic                     last;
  } req_t;

  // one result of the sorted run
  typedef struct packed {
    logic signed [DATA_W-1:0] sorted_value;
    logic                     final_res;
    logic                     overflow;
  } res_t;

  // per-cycle command broadcast to every cell of the chain
  typedef struct packed {
    logic insert;  // place the broadcast value, larger entries move up
    logic shift;   // every entry moves one place towards cell zero
  } cell_ctrl_t;

endpackage

// ===== rtl/core/isort_cell.sv =====
`timescale 1ns / 1ps
// isort_cell: one place of the sorted chain, holds one entry and its valid bit
// depends on isort_pkg
module isort_cell (
  input  logic                                    clk,
  input  logic                                    rst,
  input  isort_pkg::cell_ctrl_t                   ctrl,
  input  logic signed [isort_pkg::DATA_W-1:0]     ins_value,
  input  logic signed [isort_pkg::DATA_W-1:0]     left_value,
  input  logic                                    left_gt,
  input  logic                                    left_valid,
  input  logic signed [isort_pkg::DATA_W-1:0]     right_value,
  input  logic                                    right_valid,
  output logic signed [isort_pkg::DATA_W-1:0]     value,
  output logic                                    valid,
  output logic                                    gt
);
  import isort_pkg::*;

  logic signed [DATA_W-1:0] value_next;
  logic                     valid_next;

  // an empty place counts as larger than anything
  assign gt = !valid || (value > ins_value);

  always_comb begin
    value_next = value;
    valid_next = valid;
    if (ctrl.shift) begin
      value_next = right_value;
      valid_next = right_valid;
    end else if (ctrl.insert) begin
      valid_next = valid || left_valid;
      if (gt) begin
        value_next = left_gt ? left_value : ins_value;
      end
    end
  end

  always_ff @(posedge clk) begin
    value <= value_next;
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

endmodule

// ===== rtl/core/insertion_sorter.sv =====
`timescale 1ns / 1ps
// insertion_sorter: stable ascending sort of signed 32-bit values in a chain of cells
// order: a request is inserted in the cycle it is accepted, unless the chain is full;
//   after the last request the state turns to drain, and once the output register is
//   free, one result per cycle while the consumer takes them (count <= CAPACITY results)
// throughput: one request per cycle while collecting; no requests during the drain
// reset: synchronous, clears every cell's valid bit, the dropped flag, res_valid and the state
module insertion_sorter (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  input  isort_pkg::req_t   req,
  output logic              res_valid,
  input  logic              res_ready,
  output isort_pkg::res_t   res
);
  import isort_pkg::*;

  // state codes
  localparam logic ST_COLLECT = 1'b0;  // taking requests, building the sorted chain
  localparam logic ST_DRAIN   = 1'b1;  // shifting entries out from cell zero

  logic       state;
  logic       state_next;
  logic       dropped;
  logic       dropped_next;
  logic       res_valid_next;
  res_t       res_next;

  cell_ctrl_t ctrl;
  logic       accept;
  logic       full;
  logic       load;

  // chain wiring, one element per cell
  logic signed [DATA_W-1:0] cell_value [CAPACITY];
  logic                     cell_valid [CAPACITY];
  logic                     cell_gt    [CAPACITY];
  logic signed [DATA_W-1:0] left_value [CAPACITY];
  logic                     left_gt    [CAPACITY];
  logic                     left_valid [CAPACITY];
  logic signed [DATA_W-1:0] right_value[CAPACITY];
  logic                     right_valid[CAPACITY];

  // chain is full once the top cell holds an entry
  assign full      = cell_valid[CAPACITY-1];
  assign req_ready = (state == ST_COLLECT);
  assign accept    = req_valid && req_ready;

  // output register empty or being emptied: pop the head of the chain
  assign load = (state == ST_DRAIN) && (!res_valid || res_ready);

  assign ctrl.insert = accept && !full;
  assign ctrl.shift  = load;

  genvar i;
  generate
    for (i = 0; i < CAPACITY; i++) begin : g_cell
      // neighbour links; cell zero sees an always-occupied, never-larger left side
      if (i == 0) begin : g_first
        assign left_value[i] = req.value;
        assign left_gt[i]    = 1'b0;
        assign left_valid[i] = 1'b1;
      end else begin : g_mid
        assign left_value[i] = cell_value[i-1];
        assign left_gt[i]    = cell_gt[i-1];
        assign left_valid[i] = cell_valid[i-1];
      end
      // top cell is refilled with an empty place when draining
      if (i == CAPACITY-1) begin : g_top
        assign right_value[i] = cell_value[i];
        assign right_valid[i] = 1'b0;
      end else begin : g_low
        assign right_value[i] = cell_value[i+1];
        assign right_valid[i] = cell_valid[i+1];
      end

      isort_cell u_cell (
        .clk         (clk),
        .rst         (rst),
        .ctrl        (ctrl),
        .ins_value   (req.value),
        .left_value  (left_value[i]),
        .left_gt     (left_gt[i]),
        .left_valid  (left_valid[i]),
        .right_value (right_value[i]),
        .right_valid (right_valid[i]),
        .value       (cell_value[i]),
        .valid       (cell_valid[i]),
        .gt          (cell_gt[i])
      );
    end
  endgenerate

  // control: collect until the last request, then drain the chain
  always_comb begin
    state_next     = state;
    dropped_next   = dropped;
    res_valid_next = res_valid;
    res_next       = res;

    if (res_valid && res_ready) begin
      res_valid_next = 1'b0;
    end

    case (state)
      ST_COLLECT: begin
        if (accept) begin
          // a request that finds the chain full is lost, last or not
          if (full) begin
            dropped_next = 1'b1;
          end
          if (req.last) begin
            state_next = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        if (load) begin
          res_valid_next        = 1'b1;
          res_next.sorted_value = cell_value[0];
          // head is final when nothing sits behind it
          res_next.final_res    = !cell_valid[1];
          res_next.overflow     = dropped;
          if (!cell_valid[1]) begin
            state_next   = ST_COLLECT;
            dropped_next = 1'b0;
          end
        end
      end
      default: begin
        state_next = ST_COLLECT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    res <= res_next;
    if (rst) begin
      state     <= ST_COLLECT;
      dropped   <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      state     <= state_next;
      dropped   <= dropped_next;
      res_valid <= res_valid_next;
    end
  end

endmodule

// ===== test/insertion_sorter_test.sv =====
`timescale 1ns / 1ps
// insertion_sorter_test: self-checking bench for the insertion sorter
// depends on isort_pkg and the insertion_sorter rtl, nothing else
module insertion_sorter_test;
  import isort_pkg::*;

  // a queued request plus a flag asking the driver to wait for a full drain first
  typedef struct packed {
    logic wait_drain;
    req_t body;
  } pending_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req = '0;
  logic res_valid;
  logic res_ready = 1'b0;
  res_t res;

  insertion_sorter u_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  always #2 clk = ~clk;

  // shadow copy of the sorted store, its fill level and the dropped flag
  logic signed [DATA_W-1:0] shadow_store [CAPACITY];
  int unsigned shadow_count = 0;
  logic shadow_dropped = 1'b0;

  // sorted results still owed by the block, oldest first
  res_t sorted_q[$];
  // requests waiting to be offered
  pending_t stim_q[$];

  int unsigned errors = 0;
  int unsigned accepted = 0;
  int unsigned results_seen = 0;
  int unsigned sets_closed = 0;
  int unsigned sets_overflowed = 0;

  // insert one accepted request into the shadow store; on last, queue the sorted run
  task automatic sort_in(input req_t r);
    int pos;
    logic signed [DATA_W-1:0] v;
    res_t out;
    v = r.value;
    if (shadow_count >= CAPACITY) begin
      // no room: value lost, set marked as overflowed
      shadow_dropped = 1'b1;
    end else begin
      pos = shadow_count;
      // strictly greater entries move up, so equal values keep arrival order
      while (pos > 0 && shadow_store[pos-1] > v) begin
        shadow_store[pos] = shadow_store[pos-1];
        pos--;
      end
      shadow_store[pos] = v;
      shadow_count++;
    end
    if (r.last) begin
      for (int k = 0; k < shadow_count; k++) begin
        out.sorted_value = shadow_store[k];
        out.final_res    = (k == shadow_count - 1);
        out.overflow     = shadow_dropped;
        sorted_q.push_back(out);
      end
      sets_closed++;
      if (shadow_dropped) sets_overflowed++;
      shadow_count   = 0;
      shadow_dropped = 1'b0;
    end
  endtask

  // sender gaps: about 35 in a hundred, none over a middle stretch of requests
  function automatic logic sender_gap();
    if (accepted >= 110 && accepted < 170) return 1'b0;
    return ($urandom_range(99) < 35);
  endfunction

  // driver: keeps a request up until it is taken, then offers the next one
  always @(posedge clk) begin
    logic offer;
    pending_t nxt;
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      offer = req_valid;
      if (req_valid && req_ready) begin
        sort_in(req);
        accepted++;
        offer = 1'b0;
      end
      // only raise valid when nothing is up; a raised request never drops early
      if (!offer && stim_q.size() > 0) begin
        nxt = stim_q[0];
        if (!(nxt.wait_drain && sorted_q.size() != 0) && !sender_gap()) begin
          void'(stim_q.pop_front());
          req   <= nxt.body;
          offer = 1'b1;
        end
      end
      req_valid <= offer;
    end
  end

  // receiver state: one long hold-off to back the chain up into the request side
  int unsigned hold_left = 0;
  logic hold_done = 1'b0;

  // monitor: checks every taken result against the oldest owed one, then picks ready
  always @(posedge clk) begin
    res_t want;
    logic take;
    if (rst) begin
      res_ready <= 1'b0;
    end else begin
      if (res_valid && res_ready) begin
        if (sorted_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, nothing owed, got value %0d final %b overflow %b",
                   $time, res.sorted_value, res.final_res, res.overflow);
        end else begin
          want = sorted_q.pop_front();
          results_seen++;
          if (res.sorted_value !== want.sorted_value) begin
            errors++;
            $display("%0t: sorted_value mismatch, expected %0d actual %0d",
                     $time, want.sorted_value, res.sorted_value);
          end
          if (res.final_res !== want.final_res) begin
            errors++;
            $display("%0t: final_res mismatch, expected %b actual %b",
                     $time, want.final_res, res.final_res);
          end
          if (res.overflow !== want.overflow) begin
            errors++;
            $display("%0t: overflow mismatch, expected %b actual %b",
                     $time, want.overflow, res.overflow);
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        take = 1'b0;
      end else if (!hold_done && results_seen >= 60) begin
        // long stall while the sender keeps going, so the drain blocks new requests
        hold_left = 300;
        hold_done = 1'b1;
        take = 1'b0;
      end else if (results_seen >= 150 && results_seen < 210) begin
        take = 1'b1;
      end else begin
        take = ($urandom_range(99) >= 35);
      end
      res_ready <= take;
    end
  end

  task automatic queue_req(input logic [DATA_W-1:0] v, input logic lst, input logic hold);
    pending_t p;
    p.wait_drain = hold;
    p.body.value = v;
    p.body.last  = lst;
    stim_q.push_back(p);
  endtask

  // value mix: full range, a narrow band for duplicates, or mostly extremes
  function automatic logic [DATA_W-1:0] pick_value(input int unsigned mode);
    int unsigned r;
    if (mode == 0) return $urandom;
    if (mode == 1) return $urandom_range(8) - 4;
    r = $urandom_range(5);
    case (r)
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return 32'h0000_0000;
      3: return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    int unsigned n_items;
    int unsigned set_no;
    int unsigned len;
    int unsigned mode;
    int unsigned r;

    // directed: a lone request that closes its set at once
    queue_req(32'd7, 1'b1, 1'b0);
    // directed: extremes and duplicates, sign matters for the order
    queue_req(32'h7fff_ffff, 1'b0, 1'b0);
    queue_req(32'h8000_0000, 1'b0, 1'b0);
    queue_req(32'h0000_0000, 1'b0, 1'b0);
    queue_req(32'hffff_ffff, 1'b0, 1'b0);
    queue_req(32'h0000_0001, 1'b0, 1'b0);
    queue_req(32'h8000_0000, 1'b0, 1'b0);
    queue_req(32'h7fff_ffff, 1'b1, 1'b0);
    // directed: descending fill to capacity, the closing request is dropped for lack of room
    for (int i = 0; i <= CAPACITY; i++)
      queue_req(100 - i, (i == CAPACITY), (i == 0));
    n_items = stim_q.size();

    // random sets: mostly well-formed short sets, some exactly full, some overflowing
    set_no = 0;
    while (n_items < 280) begin
      r = $urandom_range(99);
      if (r < 12) len = CAPACITY;
      else if (r < 25) len = CAPACITY + 1 + $urandom_range(4);
      else len = 1 + $urandom_range(CAPACITY - 1);
      mode = $urandom_range(2);
      for (int i = 0; i < len; i++)
        queue_req(pick_value(mode), (i == len - 1), (i == 0 && set_no % 9 == 4));
      n_items += len;
      set_no++;
    end

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // wait for every request to go in and every owed result to come out
    while (stim_q.size() != 0 || req_valid) @(posedge clk);
    while (sorted_q.size() != 0) @(posedge clk);
    // then keep running to catch stray results
    repeat (20) @(posedge clk);

    if (sorted_q.size() != 0) begin
      errors++;
      $display("%0t: %0d results never arrived", $time, sorted_q.size());
    end
    $display("covered %0d requests in %0d sets, %0d of them overflowing capacity",
             accepted, sets_closed, sets_overflowed);
    $display("checked %0d sorted results, %0d errors", results_seen, errors);
    if (errors == 0) begin
      $display("insertion_sorter_test: clean");
    end else begin
      $display("insertion_sorter_test: errors");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("%0t: timeout", $time);
    $display("insertion_sorter_test: errors");
    $finish;
  end

endmodule

// ===== insertion_sorter.f =====
rtl/core/isort_pkg.sv
rtl/core/isort_cell.sv
rtl/core/insertion_sorter.sv
test/insertion_sorter_test.sv
